@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files; included by mission_phase_sequencer_unit.
// No dependencies; the empty forms are used when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge, masked while reset is asserted.
`define ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(name, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

@@ rtl/mps_pkg.sv @@
// Types and constants of the mission phase sequencer.
// Used by every module under rtl; depends on nothing.
package mps_pkg;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_ABORT = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_ARM      = 4'd1,
    PH_TAKEOFF  = 4'd2,
    PH_BASELINE = 4'd3,
    PH_EXPLORE  = 4'd4,
    PH_HOME     = 4'd5,
    PH_PRECISE  = 4'd6,
    PH_COAST    = 4'd7,
    PH_HOVER    = 4'd8,
    PH_ABORT    = 4'd9,
    PH_DONE     = 4'd10,
    PH_LOAD     = 4'd11
  } phase_e;

  // Register indexes (byte address = 4 * index)
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AddrW   = 5;
  localparam logic [RegIdxW-1:0] REG_TARGET_ALT = 3'd0;
  localparam logic [RegIdxW-1:0] REG_SAFE_LAND  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_DONE_ALT   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_CELL_LIMIT = 3'd3;
  localparam logic [RegIdxW-1:0] REG_HOME_TOL   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_EXPL_TMO   = 3'd5;

  localparam logic [15:0] TARGET_ALT_RST = 16'd1000;
  localparam logic [15:0] SAFE_LAND_RST  = 16'd200;
  localparam logic [15:0] DONE_ALT_RST   = 16'd50;
  localparam logic [15:0] CELL_LIMIT_RST = 16'd8;
  localparam logic [15:0] HOME_TOL_RST   = 16'd300;
  localparam logic [31:0] EXPL_TMO_RST   = 32'd600;

  localparam logic [16:0] TAKEOFF_MARGIN_MM = 17'd50;
  localparam logic [31:0] BASELINE_TICKS    = 32'd3;
  localparam logic [1:0]  FLAG_YES          = 2'd1;

  typedef struct packed {
    logic [15:0] target_altitude_mm;
    logic [15:0] safe_land_altitude_mm;
    logic [15:0] done_altitude_mm;
    logic [15:0] cell_limit;
    logic [15:0] home_tolerance_mm;
    logic [31:0] explore_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] altitude_mm;
    logic signed [15:0] home_distance_mm;
    logic [1:0]         marker_seen;
    logic [1:0]         arm_acknowledged;
    logic [15:0]        cell_count;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic        start_status;
    logic [31:0] total_ticks;
    logic [31:0] phase_ticks;
    logic [31:0] transition_count;
    logic [3:0]  previous_phase;
    logic [3:0]  entered_phase;
    logic        abort_code;
  } out_item_t;

endpackage

@@ rtl/mission_phase_sequencer_unit.sv @@
// Mission phase sequencer: input register, phase core with result register,
// APB configuration registers. Depends on mps_pkg, assert_macros.svh, mps_cfg, mps_in_stage and mps_core.
// An accepted transaction waits in the input register until the core takes it; its result is then registered.
// Throughput: one transaction per cycle while the result register is not held by out_ready_i low.
// Reset: rst_ni clears phase (idle), counters and transition record, and
//   loads the configuration defaults; no clearing pass is needed.
`include "assert_macros.svh"
module mission_phase_sequencer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  mps_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output mps_pkg::out_item_t        out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mps_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mps_pkg::*;

  cfg_t     cfg;
  logic     take;
  logic     item_valid;
  in_item_t item;

  mps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mps_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mps_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Input side stalls only behind a full, blocked result register.
  `ASSERT_RST(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> (out_valid_o && !out_ready_i), "input stalled without output backpressure")
  // A refused start leaves the mission in a running phase.
  `ASSERT_RST(a_refused_start, clk_i, rst_ni, (out_valid_o && out_data_o.start_status) |-> (out_data_o.phase != PH_IDLE && out_data_o.phase != PH_DONE && out_data_o.phase != PH_ABORT), "refused start from a startable phase")
  // A waiting transaction is neither dropped nor altered.
  `ASSERT_RST(a_item_held, clk_i, rst_ni, (item_valid && !take) |=> (item_valid && $stable(item)), "held transaction lost or changed")

endmodule

@@ rtl/mps_cfg.sv @@
// APB-style configuration register file of the mission phase sequencer.
// Depends on mps_pkg.
module mps_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [mps_pkg::AddrW-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output mps_pkg::cfg_t            cfg_o
);
  import mps_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic              wr_en;
  logic [RegIdxW-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_TARGET_ALT: cfg_d.target_altitude_mm    = pwdata[15:0];
        REG_SAFE_LAND:  cfg_d.safe_land_altitude_mm = pwdata[15:0];
        REG_DONE_ALT:   cfg_d.done_altitude_mm      = pwdata[15:0];
        REG_CELL_LIMIT: cfg_d.cell_limit            = pwdata[15:0];
        REG_HOME_TOL:   cfg_d.home_tolerance_mm     = pwdata[15:0];
        REG_EXPL_TMO:   cfg_d.explore_timeout_ticks = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_TARGET_ALT: prdata = {16'd0, cfg_q.target_altitude_mm};
      REG_SAFE_LAND:  prdata = {16'd0, cfg_q.safe_land_altitude_mm};
      REG_DONE_ALT:   prdata = {16'd0, cfg_q.done_altitude_mm};
      REG_CELL_LIMIT: prdata = {16'd0, cfg_q.cell_limit};
      REG_HOME_TOL:   prdata = {16'd0, cfg_q.home_tolerance_mm};
      REG_EXPL_TMO:   prdata = cfg_q.explore_timeout_ticks;
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_altitude_mm    <= TARGET_ALT_RST;
      cfg_q.safe_land_altitude_mm <= SAFE_LAND_RST;
      cfg_q.done_altitude_mm      <= DONE_ALT_RST;
      cfg_q.cell_limit            <= CELL_LIMIT_RST;
      cfg_q.home_tolerance_mm     <= HOME_TOL_RST;
      cfg_q.explore_timeout_ticks <= EXPL_TMO_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/mps_in_stage.sv @@
// Input register of the mission phase sequencer: holds one accepted transaction
// until the core takes it. Depends on mps_pkg.
module mps_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mps_pkg::in_item_t in_data_i,
  input  logic              take_i,
  output logic              item_valid_o,
  output mps_pkg::in_item_t item_o
);
  import mps_pkg::*;

  logic     valid_q;
  in_item_t data_q;

  // Refill in the same cycle the core drains the register.
  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

@@ rtl/mps_core.sv @@
// Phase state, counters, next-state logic and result register of the
// mission phase sequencer. Depends on mps_pkg.
module mps_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mps_pkg::cfg_t      cfg_i,
  input  logic               item_valid_i,
  input  mps_pkg::in_item_t  item_i,
  output logic               take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output mps_pkg::out_item_t out_data_o
);
  import mps_pkg::*;

  phase_e      phase_q, phase_d, tgt;
  phase_e      from_q, from_d, to_q, to_d;
  logic [31:0] tick_q, tick_d, ptc_q, ptc_d, trans_q, trans_d;
  logic        abort_q, abort_d;
  logic        refused;
  logic        out_valid_q;
  out_item_t   res_q;

  logic        alt_known, dist_known;
  logic [16:0] alt_u;
  logic [15:0] dist_u;
  cmd_e        cmd;

  assign cmd        = cmd_e'(item_i.cmd);
  assign alt_known  = !item_i.altitude_mm[15];
  assign dist_known = !item_i.home_distance_mm[15];
  assign alt_u      = {2'b00, item_i.altitude_mm[14:0]};
  assign dist_u     = {1'b0, item_i.home_distance_mm[14:0]};

  assign take_o = item_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    tick_d  = tick_q;
    ptc_d   = ptc_q;
    trans_d = trans_q;
    abort_d = abort_q;
    from_d  = from_q;
    to_d    = to_q;
    phase_d = phase_q;
    refused = 1'b0;
    tgt     = phase_q;

    unique case (cmd)
      CMD_TICK: begin
        tick_d = tick_q + 32'd1;
        ptc_d  = ptc_q + 32'd1;
        // guards see the incremented phase tick count
        unique case (phase_q)
          PH_ARM: begin
            if (item_i.arm_acknowledged == FLAG_YES && item_i.marker_seen == FLAG_YES) begin
              tgt = PH_TAKEOFF;
            end
          end
          PH_TAKEOFF: begin
            if (alt_known && (alt_u + TAKEOFF_MARGIN_MM >= {1'b0, cfg_i.target_altitude_mm})) begin
              tgt = PH_BASELINE;
            end
          end
          PH_BASELINE: begin
            if (ptc_d >= BASELINE_TICKS) begin
              tgt = PH_EXPLORE;
            end
          end
          PH_EXPLORE: begin
            if (item_i.cell_count >= cfg_i.cell_limit) begin
              tgt = PH_HOME;
            end else if (ptc_d >= cfg_i.explore_timeout_ticks) begin
              abort_d = 1'b1;
              tgt     = PH_HOME;
            end
          end
          PH_HOME: begin
            if (dist_known && dist_u < cfg_i.home_tolerance_mm) begin
              tgt = PH_PRECISE;
            end
          end
          PH_PRECISE: begin
            if (alt_known && alt_u[15:0] < cfg_i.safe_land_altitude_mm) begin
              tgt = PH_COAST;
            end
          end
          PH_COAST: begin
            if (alt_known && alt_u[15:0] < cfg_i.done_altitude_mm) begin
              tgt = PH_DONE;
            end
          end
          default: ;
        endcase
      end
      CMD_START: begin
        if (phase_q inside {PH_IDLE, PH_DONE, PH_ABORT}) begin
          tick_d  = 32'd0;
          ptc_d   = 32'd0;
          trans_d = 32'd0;
          abort_d = 1'b0;
          tgt     = PH_ARM;
        end else begin
          refused = 1'b1;
        end
      end
      CMD_STOP: begin
        if (phase_q != PH_IDLE) begin
          tgt = PH_HOME;
        end
      end
      CMD_ABORT: begin
        if (phase_q != PH_DONE && phase_q != PH_ABORT) begin
          tgt = PH_ABORT;
        end
      end
      default: ;
    endcase

    if (tgt != phase_q) begin
      from_d  = phase_q;
      to_d    = tgt;
      phase_d = tgt;
      ptc_d   = 32'd0;
      trans_d = trans_d + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      from_q      <= PH_IDLE;
      to_q        <= PH_IDLE;
      tick_q      <= 32'd0;
      ptc_q       <= 32'd0;
      trans_q     <= 32'd0;
      abort_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      phase_q     <= phase_d;
      from_q      <= from_d;
      to_q        <= to_d;
      tick_q      <= tick_d;
      ptc_q       <= ptc_d;
      trans_q     <= trans_d;
      abort_q     <= abort_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q.phase            <= phase_d;
      res_q.start_status     <= refused;
      res_q.total_ticks      <= tick_d;
      res_q.phase_ticks      <= ptc_d;
      res_q.transition_count <= trans_d;
      res_q.previous_phase   <= from_d;
      res_q.entered_phase    <= to_d;
      res_q.abort_code       <= abort_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule
